// ===== sv/bldc_pkg.sv =====
// Package for the six-step commutator: request and result types, register
// indexes, reset values and the commutation step tables.
// Depends on nothing; used by the core, its checker and its testbench.
package bldc_pkg;

    // Default width of the open-loop delay and tick counter.
    localparam int DELAY_WIDTH_DEFAULT = 16;

    // Configuration register widths and reset values.
    localparam int CFG_DATA_W = 16;
    localparam logic [15:0] RAMP_START_RESET = 16'd3500;
    localparam logic [15:0] RAMP_END_RESET   = 16'd1000;
    localparam logic [7:0]  RAMP_DEC_RESET   = 8'd5;
    localparam logic [7:0]  QUALIFY_RESET    = 8'd10;

    // Commutation sequence has six steps, numbered from zero.
    localparam logic [2:0] STEP_LAST = 3'd5;

    // Drive pattern: bits 2:0 high side, bits 5:3 low side.
    localparam logic [5:0] DRIVE_OFF = 6'd0;
    // Sense selection: bits 1:0 phase, bit 2 set for a rising edge.
    localparam logic [2:0] SENSE_RESET = 3'b100;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_RAMP_START = 2'd0,
        CFG_RAMP_END   = 2'd1,
        CFG_RAMP_DEC   = 2'd2,
        CFG_QUALIFY    = 2'd3
    } t_cfg_reg;

    // Operating mode, also reported on the result.
    typedef enum logic [1:0] {
        MODE_STOPPED = 2'd0,
        MODE_RAMP    = 2'd1,
        MODE_CLOSED  = 2'd2
    } t_mode;

    // One timer tick request.
    typedef struct packed {
        logic button_pressed;
        logic comparator_out;
    } t_in_item;

    // One result per tick.
    typedef struct packed {
        logic [2:0] high_side_enable;
        logic [2:0] low_side_on;
        logic [1:0] sense_phase;
        logic       sense_rising;
        logic       commutated;
        logic [1:0] run_mode;
    } t_out_item;

    // Bridge pattern of each step: AH-BL, AH-CL, BH-CL, BH-AL, CH-AL, CH-BL.
    function automatic logic [5:0] step_drive(input logic [2:0] step);
        logic [5:0] pattern;
        case (step)
            3'd1:    pattern = {3'b100, 3'b001};
            3'd2:    pattern = {3'b100, 3'b010};
            3'd3:    pattern = {3'b001, 3'b010};
            3'd4:    pattern = {3'b001, 3'b100};
            3'd5:    pattern = {3'b010, 3'b100};
            default: pattern = {3'b010, 3'b001};
        endcase
        return pattern;
    endfunction

    // Floating phase and expected edge of each step:
    // C rising, B falling, A rising, C falling, B rising, A falling.
    function automatic logic [2:0] step_sense(input logic [2:0] step);
        logic [2:0] sel;
        case (step)
            3'd1:    sel = {1'b0, 2'd1};
            3'd2:    sel = {1'b1, 2'd0};
            3'd3:    sel = {1'b0, 2'd2};
            3'd4:    sel = {1'b1, 2'd1};
            3'd5:    sel = {1'b0, 2'd0};
            default: sel = {1'b1, 2'd2};
        endcase
        return sel;
    endfunction

endpackage

// ===== sv/bldc_six_step_commutator_core.sv =====
// Six-step commutator core for a sensorless brushless DC motor bridge.
// Depends on bldc_pkg for the request and result types, register indexes
// and step tables.
//
// Each request is one timer tick carrying the run button level and the
// back-EMF comparator sample; each request gives exactly one result, which
// shows the bridge pattern, the watched phase and edge, the run mode and
// whether the tick commutated. A request is taken in every cycle in which
// o_in_stall is low: the whole state update is one pass of compares and
// counters, written at the accepting edge into the state registers and the
// result register, or the skid register while a result is held. The result
// side has a two-entry buffer (result register plus skid register); o_in_stall
// rises only while both are full. No clearing pass follows reset. Configuration
// writes are always ready and must only be made while the block is idle.
// DELAY_WIDTH sets the width of the open-loop delay and tick counter.
module bldc_six_step_commutator_core #(
    parameter int DELAY_WIDTH = bldc_pkg::DELAY_WIDTH_DEFAULT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Tick requests
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  bldc_pkg::t_in_item                   i_in,
    // Results
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output bldc_pkg::t_out_item                  o_out,
    // Configuration writes
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  bldc_pkg::t_cfg_reg                   i_cfg_index,
    input  logic [bldc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    // Compare width wide enough for both the delay and the 16-bit end delay.
    localparam int CMP_W = (DELAY_WIDTH > 16) ? DELAY_WIDTH : 16;

    // Configuration registers.
    logic [15:0] r_ramp_start;
    logic [15:0] r_ramp_end;
    logic [7:0]  r_ramp_dec;
    logic [7:0]  r_qualify;

    // Commutator state.
    logic [2:0]             r_step, n_step;
    bldc_pkg::t_mode        r_mode, n_mode;
    logic [DELAY_WIDTH-1:0] r_delay, n_delay;
    logic [DELAY_WIDTH-1:0] r_tick, n_tick;
    logic [7:0]             r_good, n_good;
    logic                   r_qual, n_qual;
    logic                   r_prev_comp;
    logic [5:0]             r_drive, n_drive;
    logic [2:0]             r_sense, n_sense;

    // Result buffer.
    logic                   r_out_valid;
    bldc_pkg::t_out_item    r_out;
    logic                   r_skid_valid;
    bldc_pkg::t_out_item    r_skid;

    logic                   in_accept;
    logic                   out_pop;
    logic                   done;
    logic [2:0]             step_safe;
    logic [DELAY_WIDTH-1:0] tick_inc;
    logic [DELAY_WIDTH-1:0] dec_ext;
    logic [DELAY_WIDTH-1:0] delay_dec;
    logic [DELAY_WIDTH-1:0] start_trunc;
    logic [7:0]             good_inc;
    logic                   want;
    bldc_pkg::t_out_item    n_result;

    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_pop     = r_out_valid && !i_out_stall;
    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_start <= bldc_pkg::RAMP_START_RESET;
            r_ramp_end   <= bldc_pkg::RAMP_END_RESET;
            r_ramp_dec   <= bldc_pkg::RAMP_DEC_RESET;
            r_qualify    <= bldc_pkg::QUALIFY_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                bldc_pkg::CFG_RAMP_START: r_ramp_start <= i_cfg_data;
                bldc_pkg::CFG_RAMP_END:   r_ramp_end   <= i_cfg_data;
                bldc_pkg::CFG_RAMP_DEC:   r_ramp_dec   <= i_cfg_data[7:0];
                bldc_pkg::CFG_QUALIFY:    r_qualify    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Operands shared by the update logic.
    assign step_safe   = (r_step > bldc_pkg::STEP_LAST) ? 3'd0 : r_step;
    assign tick_inc    = r_tick + DELAY_WIDTH'(1);
    assign dec_ext     = DELAY_WIDTH'(r_ramp_dec);
    assign delay_dec   = (r_delay > dec_ext) ? (r_delay - dec_ext) : '0;
    assign start_trunc = DELAY_WIDTH'(r_ramp_start);
    assign good_inc    = r_good + 8'd1;
    assign want        = r_sense[2];

    // Next state for one tick.
    always_comb begin
        n_step  = r_step;
        n_mode  = r_mode;
        n_delay = r_delay;
        n_tick  = r_tick;
        n_good  = r_good;
        n_qual  = r_qual;
        n_drive = r_drive;
        n_sense = r_sense;
        done    = 1'b0;
        if (!i_in.button_pressed) begin
            n_mode  = bldc_pkg::MODE_STOPPED;
            n_drive = bldc_pkg::DRIVE_OFF;
            n_delay = start_trunc;
            n_tick  = '0;
            n_good  = 8'd0;
            n_qual  = 1'b0;
        end else begin
            // Leaving stopped: pick ramp or go straight to closed loop.
            if (r_mode != bldc_pkg::MODE_RAMP && r_mode != bldc_pkg::MODE_CLOSED) begin
                n_mode = (CMP_W'(r_delay) <= CMP_W'(r_ramp_end)) ?
                         bldc_pkg::MODE_CLOSED : bldc_pkg::MODE_RAMP;
                n_tick = '0;
                n_good = 8'd0;
                n_qual = 1'b0;
            end
            if (n_mode == bldc_pkg::MODE_RAMP) begin
                // Open-loop ramp: commutate when the tick count reaches the delay.
                n_tick = (r_mode == bldc_pkg::MODE_RAMP) ? tick_inc : DELAY_WIDTH'(1);
                if (n_tick >= r_delay) begin
                    done    = 1'b1;
                    n_tick  = '0;
                    n_delay = delay_dec;
                    if (CMP_W'(delay_dec) <= CMP_W'(r_ramp_end)) begin
                        n_mode = bldc_pkg::MODE_CLOSED;
                        n_qual = 1'b0;
                        n_good = 8'd0;
                    end
                end
            end else begin
                // Closed loop: wait for the edge, then count matching samples.
                if (!n_qual) begin
                    if (r_prev_comp != i_in.comparator_out && i_in.comparator_out == want) begin
                        n_qual = 1'b1;
                        n_good = 8'd0;
                    end
                end else if (i_in.comparator_out == want) begin
                    n_good = good_inc;
                    if (good_inc >= r_qualify) begin
                        done   = 1'b1;
                        n_qual = 1'b0;
                        n_good = 8'd0;
                    end
                end
            end
            // Commutation applies the current step and advances the index.
            if (done) begin
                n_drive = bldc_pkg::step_drive(step_safe);
                n_sense = bldc_pkg::step_sense(step_safe);
                n_step  = (step_safe == bldc_pkg::STEP_LAST) ? 3'd0 : step_safe + 3'd1;
            end
        end
    end

    // Result of this tick, showing the state after it.
    always_comb begin
        n_result.high_side_enable = n_drive[2:0];
        n_result.low_side_on      = n_drive[5:3];
        n_result.sense_phase      = n_sense[1:0];
        n_result.sense_rising     = n_sense[2];
        n_result.commutated       = done;
        n_result.run_mode         = n_mode;
    end

    // State registers, updated on each accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= 3'd0;
            r_mode      <= bldc_pkg::MODE_STOPPED;
            r_delay     <= DELAY_WIDTH'(bldc_pkg::RAMP_START_RESET);
            r_tick      <= '0;
            r_good      <= 8'd0;
            r_qual      <= 1'b0;
            r_prev_comp <= 1'b0;
            r_drive     <= bldc_pkg::DRIVE_OFF;
            r_sense     <= bldc_pkg::SENSE_RESET;
        end else if (in_accept) begin
            r_step      <= n_step;
            r_mode      <= n_mode;
            r_delay     <= n_delay;
            r_tick      <= n_tick;
            r_good      <= n_good;
            r_qual      <= n_qual;
            r_prev_comp <= i_in.comparator_out;
            r_drive     <= n_drive;
            r_sense     <= n_sense;
        end
    end

    // Result register and skid register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (out_pop) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end
            end else if (r_out_valid && !out_pop) begin
                if (in_accept) begin
                    r_skid_valid <= 1'b1;
                end
            end else begin
                r_out_valid <= in_accept;
            end
        end
    end

    // Result and skid payloads.
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_pop) begin
                r_out <= r_skid;
            end
        end else if (r_out_valid && !out_pop) begin
            if (in_accept) begin
                r_skid <= n_result;
            end
        end else if (in_accept) begin
            r_out <= n_result;
        end
    end

`ifndef SYNTHESIS
    // The skid register only fills behind a held result.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a result while the result register is empty");

    // The step index stays within the six-step sequence.
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= bldc_pkg::STEP_LAST)
        else $error("step index outside the commutation sequence");

    // A stopped motor has every switch off.
    a_stopped_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == bldc_pkg::MODE_STOPPED |-> r_drive == bldc_pkg::DRIVE_OFF)
        else $error("bridge driven while stopped");

    // A commutating result always carries a live bridge pattern.
    a_commutate_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.commutated) |->
            (o_out.high_side_enable != 3'd0 && o_out.low_side_on != 3'd0))
        else $error("commutation reported with the bridge off");

    // A request accepted into a free result register is offered next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !r_out_valid) |=> o_out_valid)
        else $error("accepted request produced no result");
`endif

endmodule

// ===== test/bldc_six_step_commutator_checker.sv =====
// Checker for the six-step commutator core: watches the tick, result and register
// channels, predicts each result from its own model of the commutator and compares.
// Depends on bldc_pkg for the request, result, mode and register index types.
module bldc_six_step_commutator_checker
    import bldc_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  t_in_item                   i_in,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  t_out_item                  i_out,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  t_cfg_reg                   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_checked,
    output int                         o_commutations
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SHOWN = 10;

    // Register copies.
    logic [15:0] start_delay;
    logic [15:0] end_delay;
    logic [7:0]  decrement;
    logic [7:0]  qualify_target;

    // Commutator state as the predictor sees it.
    logic [2:0]  next_step;
    t_mode       run_state;
    logic [15:0] delay_now;
    logic [15:0] ticks_since;
    logic [7:0]  good_hits;
    logic        hunting;
    logic        last_comp;
    logic [5:0]  bridge;
    logic [2:0]  watch;

    t_out_item   commutator_reports[$];
    t_out_item   oldest;
    t_out_item   predicted;
    int          fail_total;
    int          checked_total;
    int          commutation_total;

    assign o_fail_count   = fail_total;
    assign o_pending      = commutator_reports.size();
    assign o_checked      = checked_total;
    assign o_commutations = commutation_total;

    // Bridge switches per step, low side in bits 5:3 and high side in bits 2:0.
    function automatic logic [5:0] bridge_for(input logic [2:0] step);
        case (step)
            3'd1:    return {3'b100, 3'b001};
            3'd2:    return {3'b100, 3'b010};
            3'd3:    return {3'b001, 3'b010};
            3'd4:    return {3'b001, 3'b100};
            3'd5:    return {3'b010, 3'b100};
            default: return {3'b010, 3'b001};
        endcase
    endfunction

    // Floating phase to watch per step, with the expected edge in bit 2.
    function automatic logic [2:0] watch_for(input logic [2:0] step);
        case (step)
            3'd1:    return {1'b0, 2'd1};
            3'd2:    return {1'b1, 2'd0};
            3'd3:    return {1'b0, 2'd2};
            3'd4:    return {1'b1, 2'd1};
            3'd5:    return {1'b0, 2'd0};
            default: return {1'b1, 2'd2};
        endcase
    endfunction

    // Apply the pattern of the current step and move on to the next one.
    task automatic advance_step();
        logic [2:0] step;
        step      = (next_step <= STEP_LAST) ? next_step : 3'd0;
        bridge    = bridge_for(step);
        watch     = watch_for(step);
        next_step = (step == STEP_LAST) ? 3'd0 : step + 3'd1;
    endtask

    // One timer tick: update the state and form the result it shows.
    task automatic step_commutator(input t_in_item req, output t_out_item res);
        logic fired;
        logic want;
        fired = 1'b0;
        if (!req.button_pressed) begin
            run_state   = MODE_STOPPED;
            bridge      = DRIVE_OFF;
            delay_now   = start_delay;
            ticks_since = '0;
            good_hits   = '0;
            hunting     = 1'b0;
        end else begin
            // A press picks the ramp, or closed loop if the delay is already short.
            if (run_state == MODE_STOPPED) begin
                run_state   = (delay_now <= end_delay) ? MODE_CLOSED : MODE_RAMP;
                ticks_since = '0;
                good_hits   = '0;
                hunting     = 1'b0;
            end
            if (run_state == MODE_RAMP) begin
                ticks_since = ticks_since + 16'd1;
                if (ticks_since >= delay_now) begin
                    advance_step();
                    fired       = 1'b1;
                    ticks_since = '0;
                    delay_now   = (delay_now > {8'd0, decrement}) ?
                                  delay_now - {8'd0, decrement} : 16'd0;
                    if (delay_now <= end_delay) begin
                        run_state = MODE_CLOSED;
                        hunting   = 1'b0;
                        good_hits = '0;
                    end
                end
            end else begin
                // Closed loop: an edge towards the wanted level opens qualification,
                // and matching samples from the next tick on are counted.
                want = watch[2];
                if (!hunting) begin
                    if (last_comp != req.comparator_out && req.comparator_out == want) begin
                        hunting   = 1'b1;
                        good_hits = '0;
                    end
                end else if (req.comparator_out == want) begin
                    good_hits = good_hits + 8'd1;
                    if (good_hits >= qualify_target) begin
                        advance_step();
                        fired     = 1'b1;
                        hunting   = 1'b0;
                        good_hits = '0;
                    end
                end
            end
        end
        last_comp = req.comparator_out;

        res.high_side_enable = bridge[2:0];
        res.low_side_on      = bridge[5:3];
        res.sense_phase      = watch[1:0];
        res.sense_rising     = watch[2];
        res.commutated       = fired;
        res.run_mode         = run_state;
    endtask

    // Register writes, result comparison and request prediction at each edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start_delay       = RAMP_START_RESET;
            end_delay         = RAMP_END_RESET;
            decrement         = RAMP_DEC_RESET;
            qualify_target    = QUALIFY_RESET;
            next_step         = '0;
            run_state         = MODE_STOPPED;
            delay_now         = RAMP_START_RESET;
            ticks_since       = '0;
            good_hits         = '0;
            hunting           = 1'b0;
            last_comp         = 1'b0;
            bridge            = DRIVE_OFF;
            watch             = SENSE_RESET;
            fail_total        = 0;
            checked_total     = 0;
            commutation_total = 0;
            commutator_reports.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_RAMP_START: start_delay    = i_cfg_data[15:0];
                    CFG_RAMP_END:   end_delay      = i_cfg_data[15:0];
                    CFG_RAMP_DEC:   decrement      = i_cfg_data[7:0];
                    CFG_QUALIFY:    qualify_target = i_cfg_data[7:0];
                    default: ;
                endcase
            end

            if (i_out_valid && !i_out_stall) begin
                checked_total++;
                if (i_out.commutated === 1'b1)
                    commutation_total++;
                if (commutator_reports.size() == 0) begin
                    fail_total++;
                    if (fail_total <= MAX_SHOWN)
                        $display("%0t: result %0d arrived with nothing expected", $realtime,
                                 checked_total);
                end else begin
                    oldest = commutator_reports.pop_front();
                    if (i_out.high_side_enable !== oldest.high_side_enable ||
                        i_out.low_side_on      !== oldest.low_side_on ||
                        i_out.sense_phase      !== oldest.sense_phase ||
                        i_out.sense_rising     !== oldest.sense_rising ||
                        i_out.commutated       !== oldest.commutated ||
                        i_out.run_mode         !== oldest.run_mode) begin
                        fail_total++;
                        if (fail_total <= MAX_SHOWN)
                            $display({"%0t: result %0d expected hs=%b ls=%b ph=%0d rise=%b ",
                                      "comm=%b mode=%0d, got hs=%b ls=%b ph=%0d rise=%b ",
                                      "comm=%b mode=%0d"},
                                     $realtime, checked_total,
                                     oldest.high_side_enable, oldest.low_side_on,
                                     oldest.sense_phase, oldest.sense_rising,
                                     oldest.commutated, oldest.run_mode,
                                     i_out.high_side_enable, i_out.low_side_on,
                                     i_out.sense_phase, i_out.sense_rising,
                                     i_out.commutated, i_out.run_mode);
                    end
                end
            end

            if (i_in_valid && !i_in_stall) begin
                step_commutator(i_in, predicted);
                commutator_reports.push_back(predicted);
            end
        end
    end

endmodule

// ===== test/bldc_six_step_commutator_core_tb.sv =====
// Top of the commutator testbench: clock, reset, tick requests, register writes and
// result stalls around the core, with the verdict taken from the checker.
// Depends on bldc_pkg, bldc_six_step_commutator_core and bldc_six_step_commutator_checker.
module bldc_six_step_commutator_core_tb;
    import bldc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TICK_TARGET = 1250;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    t_in_item              in_req    = '0;
    logic                  out_stall = 1'b0;
    logic                  cfg_valid = 1'b0;
    t_cfg_reg              cfg_index = CFG_RAMP_START;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic                  in_stall;
    logic                  out_valid;
    t_out_item             out_res;
    logic                  cfg_ready;

    int fail_count;
    int pending;
    int checked;
    int commutations;

    int ticks_sent      = 0;
    int settings_loaded = 0;
    bit gaps_on         = 1'b1;
    int hold_cycles     = 0;

    always #5 clk = ~clk;

    bldc_six_step_commutator_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_res),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    bldc_six_step_commutator_checker checker_inst (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_in           (in_req),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_out          (out_res),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_commutations (commutations)
    );

    // Offer one tick request, after a random gap while gaps are on, and hold it until it is taken.
    task automatic send_tick(input logic button, input logic comp);
        int gap;
        gap = gaps_on ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= {button, comp};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        ticks_sent++;
    endtask

    // Withdraw the request and wait until every result has come back.
    task automatic await_results();
        in_valid <= 1'b0;
        wait (checked == ticks_sent);
    endtask

    task automatic put_register(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // Write all four registers while the core is idle; the byte-wide ones carry
    // random upper bits that must be ignored.
    task automatic load_settings(input logic [15:0] start_v, input logic [15:0] end_v,
                                 input logic [7:0] dec_v, input logic [7:0] qual_v);
        await_results();
        cfg_valid <= 1'b1;
        put_register(CFG_RAMP_START, start_v);
        put_register(CFG_RAMP_END, end_v);
        put_register(CFG_RAMP_DEC, {8'($urandom_range(0, 255)), dec_v});
        put_register(CFG_QUALIFY, {8'($urandom_range(0, 255)), qual_v});
        cfg_valid <= 1'b0;
        settings_loaded++;
    endtask

    // A release tick to reload the ramp, then a square-wave comparator whose half
    // periods follow the qualify count, with occasional glitches and releases.
    task automatic run_phase(input int n_ticks, input int half_min, input int half_max,
                             input int release_pct, input int noise_pct);
        logic level;
        logic button;
        logic comp;
        int   run_left;
        int   roll;
        level    = 1'($urandom_range(0, 1));
        run_left = 0;
        send_tick(1'b0, 1'($urandom_range(0, 1)));
        for (int i = 0; i < n_ticks; i++) begin
            if (run_left == 0) begin
                level    = ~level;
                run_left = $urandom_range(half_min, half_max);
            end
            run_left--;
            roll   = $urandom_range(0, 99);
            button = (roll >= release_pct);
            comp   = (roll >= 100 - noise_pct) ? ~level : level;
            send_tick(button, comp);
        end
    endtask

    // Result side: a random stall before each result while gaps are on, and a long hold on request.
    initial begin : result_side
        int stall_len;
        forever begin
            if (hold_cycles > 0) begin
                out_stall <= 1'b1;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            stall_len = gaps_on ? $urandom_range(0, 19) : 0;
            if (stall_len > 0) begin
                out_stall <= 1'b1;
                repeat (stall_len) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!(out_valid && !out_stall)) @(posedge clk);
        end
    end

    // Stimulus and verdict.
    initial begin : tick_side
        int phase;
        int qual;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: stopped outputs, then a press that begins the long ramp.
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);

        // Zero start delay skips the ramp; a zero qualify count acts like one.
        load_settings(16'd0, 16'd0, 8'd255, 8'd0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b0);

        // Shortest ramp: one commutation, then the delay reaches zero.
        load_settings(16'd1, 16'd0, 8'd1, 8'd1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b0);

        // All registers at their maxima: the press goes straight to closed loop.
        load_settings(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);

        phase = 0;
        while (ticks_sent < TICK_TARGET) begin
            case (phase)
                0: begin
                    // Large decrement clamps the delay at zero after two ramp steps.
                    gaps_on = 1'b1;
                    load_settings(16'd300, 16'd0, 8'd255, 8'd3);
                    run_phase(380, 4, 8, 0, 0);
                end
                1: begin
                    // Widest qualify count with half periods just long enough.
                    gaps_on = 1'b0;
                    load_settings(16'd3, 16'd2, 8'd1, 8'd255);
                    run_phase(280, 256, 262, 0, 0);
                end
                2: begin
                    // Long result hold while ticks keep coming, so the core fills up.
                    gaps_on = 1'b0;
                    load_settings(16'($urandom_range(2, 20)), 16'($urandom_range(0, 5)),
                                  8'($urandom_range(1, 6)), 8'($urandom_range(1, 4)));
                    hold_cycles = 80;
                    run_phase(120, 5, 9, 1, 4);
                end
                3: begin
                    // No decrement at all, with heavy noise and frequent releases.
                    gaps_on = 1'b1;
                    load_settings(16'($urandom_range(1, 12)), 16'($urandom_range(0, 12)),
                                  8'd0, 8'($urandom_range(0, 3)));
                    run_phase(90, 1, 4, 30, 40);
                end
                default: begin
                    gaps_on = ($urandom_range(0, 3) != 0);
                    qual    = $urandom_range(0, 6);
                    load_settings(16'($urandom_range(0, 40)), 16'($urandom_range(0, 20)),
                                  8'($urandom_range(1, 15)), 8'(qual));
                    run_phase($urandom_range(40, 70), qual + 1, qual + 6,
                              $urandom_range(0, 2), $urandom_range(0, 8));
                    // Sender pauses for the core to drain, then carries on.
                    await_results();
                    run_phase($urandom_range(30, 60), qual + 1, qual + 6, 0,
                              $urandom_range(0, 5));
                end
            endcase
            phase++;
        end

        // Drain: no more ticks, no more stalls, then a short settling time.
        in_valid <= 1'b0;
        gaps_on = 1'b0;
        wait (checked == ticks_sent);
        repeat (20) @(posedge clk);

        $display("Covered %0d ticks over %0d register settings and %0d random phases.",
                 ticks_sent, settings_loaded, phase);
        $display("Checked %0d results including %0d commutations; %0d failures.",
                 checked, commutations, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("bldc_six_step_commutator_core: match");
        end else begin
            $display("bldc_six_step_commutator_core: mismatch");
        end
        $finish;
    end

    // Watchdog for a hung handshake or a missing result.
    initial begin : watchdog
        #2_000_000;
        $display("bldc_six_step_commutator_core: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/bldc_pkg.sv
sv/bldc_six_step_commutator_core.sv
test/bldc_six_step_commutator_checker.sv
test/bldc_six_step_commutator_core_tb.sv
